// ===== rtl/wgrt_pkg.sv =====
// Package for the weighted gateway route table: shared types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
package wgrt_pkg;

	localparam int MaxRoutesDef   = 16;
	localparam int MaxGatewaysDef = 8;
	localparam int HeaderBytesDef = 72;
	localparam int LoadW          = 24;
	localparam logic [LoadW-1:0] LoadMask = 24'hffffff;
	localparam int NobW           = 21;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_NOTIFY = 2'd2,
		FUNC_FWD    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVAL   = 3'd1,
		ST_NOENT   = 3'd2,
		ST_UNREACH = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CFG_FWD_EN = 3'd0,
		CFG_NET0   = 3'd1,
		CFG_NET1   = 3'd2,
		CFG_NET2   = 3'd3,
		CFG_NET3   = 3'd4,
		CFG_NETVAL = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GWSCAN,
		S_ADD,
		S_DEL,
		S_NOTIFY,
		S_FWD,
		S_FWD_UPD,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_req;   // capture the request
		logic    gw_start;   // reset gateway search
		logic    gw_step;    // examine one gateway slot
		logic    add_commit; // perform add with search result
		logic    scan_start; // reset route scan
		logic    del_step;   // examine one route for delete
		logic    del_finish; // commit compacted count
		logic    notify_do;  // apply notify with search result
		logic    fwd_step;   // examine one route for forward
		logic    fwd_finish; // charge the chosen gateway
		logic    out_load;   // load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		func_t req_func;   // function of the request being offered
		func_t func;       // function of the captured request
		logic  gw_last;    // gateway search finished this step
		logic  scan_last;  // route scan has no more entries
	} sts_t;

	// Wrapped 24-bit compare: a comes before b.
	function automatic logic load_better(input logic [LoadW-1:0] a, input logic [LoadW-1:0] b);
		logic [LoadW-1:0] d;
		d = a - b;
		return d > (LoadMask >> 1);
	endfunction

endpackage

// ===== rtl/wgrt_if.sv =====
// Valid/ready channel carrying one request or result payload.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
interface wgrt_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/wgrt_ctrl.sv =====
// Controller state machine for the route table: sequences searches and scans.
// Depends on wgrt_pkg.
`timescale 1ns / 1ps
module wgrt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  wgrt_pkg::sts_t   sts,
	output wgrt_pkg::cmd_t   cmd
);
	wgrt_pkg::state_t state_q, state_d;
	logic out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= wgrt_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// Result holding flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			wgrt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					cmd.gw_start = 1'b1;
					cmd.scan_start = 1'b1;
					state_d = (sts.req_func == wgrt_pkg::FUNC_DELETE) ? wgrt_pkg::S_DEL :
						(sts.req_func == wgrt_pkg::FUNC_FWD) ? wgrt_pkg::S_FWD :
						wgrt_pkg::S_GWSCAN;
				end
			end
			wgrt_pkg::S_GWSCAN: begin
				cmd.gw_step = 1'b1;
				if (sts.gw_last)
					state_d = (sts.func == wgrt_pkg::FUNC_ADD) ? wgrt_pkg::S_ADD :
						wgrt_pkg::S_NOTIFY;
			end
			wgrt_pkg::S_ADD: begin
				cmd.add_commit = 1'b1;
				state_d = wgrt_pkg::S_DONE;
			end
			wgrt_pkg::S_NOTIFY: begin
				cmd.notify_do = 1'b1;
				state_d = wgrt_pkg::S_DONE;
			end
			wgrt_pkg::S_DEL: begin
				if (sts.scan_last) begin
					cmd.del_finish = 1'b1;
					state_d = wgrt_pkg::S_DONE;
				end else cmd.del_step = 1'b1;
			end
			wgrt_pkg::S_FWD: begin
				if (sts.scan_last) state_d = wgrt_pkg::S_FWD_UPD;
				else cmd.fwd_step = 1'b1;
			end
			wgrt_pkg::S_FWD_UPD: begin
				cmd.fwd_finish = 1'b1;
				state_d = wgrt_pkg::S_DONE;
			end
			wgrt_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = wgrt_pkg::S_IDLE;
				end
			end
			default: state_d = wgrt_pkg::S_IDLE;
		endcase
	end

	// A result is loaded only when the holding register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten");
	// A request is taken only in idle.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |-> state_q == wgrt_pkg::S_IDLE)
		else $error("request taken while busy");
	// After a result is loaded the controller is idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == wgrt_pkg::S_IDLE)
		else $error("not idle after result");
endmodule

// ===== rtl/wgrt_dp.sv =====
// Datapath for the route table: route and gateway stores, scan pointers, result register.
// Depends on wgrt_pkg.
`timescale 1ns / 1ps
module wgrt_dp #(
	parameter int MAX_ROUTES   = wgrt_pkg::MaxRoutesDef,
	parameter int MAX_GATEWAYS = wgrt_pkg::MaxGatewaysDef,
	parameter int HEADER_BYTES = wgrt_pkg::HeaderBytesDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wgrt_pkg::cmd_t        cmd,
	output wgrt_pkg::sts_t        sts,
	// request fields
	input  logic [1:0]            func,
	input  logic [31:0]           dest_net,
	input  logic [63:0]           node_id,
	input  logic [31:0]           src_net,
	input  logic                  from_interface,
	input  logic                  alive,
	input  logic [31:0]           event_time,
	input  logic [31:0]           current_time,
	input  logic [20:0]           payload_bytes,
	// configuration
	input  logic                  fwd_en,
	input  logic [3:0][31:0]      lnet,
	input  logic [3:0]            lnet_valid,
	// result
	output logic [2:0]            status,
	output logic [63:0]           gateway_id,
	output logic [1:0]            out_port,
	output logic                  state_changed
);
	localparam int RW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
	localparam int CW = $clog2(MAX_ROUTES + 1);
	localparam int GW = (MAX_GATEWAYS > 1) ? $clog2(MAX_GATEWAYS) : 1;
	localparam int UW = CW;
	localparam int LW = wgrt_pkg::LoadW;
	localparam int Half = HEADER_BYTES / 2;
	localparam logic [GW:0] GwLast = (GW+1)'(MAX_GATEWAYS - 1);
	// Division by the header size as a reciprocal multiplication, exact for
	// every dividend below 2^RndW.
	localparam int RndW = wgrt_pkg::NobW + 1;
	localparam int DivL = $clog2(HEADER_BYTES);
	localparam int DivK = RndW + DivL;
	localparam logic [63:0] DivM =
		((64'd1 << DivK) + 64'(HEADER_BYTES - 1)) / 64'(HEADER_BYTES);
	localparam logic [23:0] DivM24 = DivM[23:0];

	// Captured request.
	logic [1:0]  func_q;
	logic [31:0] tnet_q, src_q, when_q, now_q;
	logic [63:0] node_q;
	logic        fromif_q, alive_q;
	logic [20:0] nob_q;

	// Stores.
	logic [31:0]        rnet_q [MAX_ROUTES];
	logic [GW-1:0]      rgw_q  [MAX_ROUTES];
	logic [CW-1:0]      rcount_q;
	logic [63:0]        gnode_q [MAX_GATEWAYS];
	logic [MAX_GATEWAYS-1:0] guse_q;
	logic               gup_q [MAX_GATEWAYS];
	logic [31:0]        gstamp_q [MAX_GATEWAYS];
	logic [LW-1:0]      gload_q [MAX_GATEWAYS];
	logic [UW-1:0]      gusers_q [MAX_GATEWAYS];

	// Scan state.
	logic [GW:0]   gptr_q;
	logic          ghit_q, gfree_q;
	logic [GW-1:0] ghit_idx_q, gfree_idx_q;
	logic [CW-1:0] rptr_q;   // delete: read index; forward: remaining count
	logic [CW-1:0] wptr_q;
	logic          hit_q;
	logic          best_v_q;
	logic [GW-1:0] best_q;
	logic [1:0]    best_port_q;

	logic [CW-1:0] rtop;
	logic [RW-1:0] ridx;
	logic [GW-1:0] cur_g, gp;
	logic [31:0]   gnet;
	logic          del_m, port_ok, fwd_ok;
	logic [1:0]    port_sel;
	logic [RndW-1:0] nob_rnd;
	logic [45:0]   prod, quo_w;
	logic [20:0]   charge_q;
	logic [2:0]    st_d;
	logic          chg_d;

	assign gp = gptr_q[GW-1:0];
	assign rtop = rptr_q - CW'(1);
	assign ridx = (func_q == wgrt_pkg::FUNC_FWD) ? rtop[RW-1:0] : rptr_q[RW-1:0];
	assign cur_g = rgw_q[ridx];
	assign gnet = gnode_q[cur_g][63:32];

	assign sts.req_func = wgrt_pkg::func_t'(func);
	assign sts.func = wgrt_pkg::func_t'(func_q);
	assign sts.gw_last = (gptr_q == GwLast);
	assign sts.scan_last = (func_q == wgrt_pkg::FUNC_FWD) ? (rptr_q == '0) :
		(rptr_q >= rcount_q);

	// Delete match on the current route.
	assign del_m = ((tnet_q == 32'hffffffff) || (tnet_q == rnet_q[ridx])) &&
		((node_q == 64'hffffffffffffffff) || (node_q == gnode_q[cur_g]));

	// Lowest valid local interface on the gateway's net.
	always_comb begin
		port_ok = 1'b0;
		port_sel = '0;
		for (int i = 3; i >= 0; i--) begin
			if (lnet_valid[i] && lnet[i] == gnet) begin
				port_ok = 1'b1;
				port_sel = 2'(i);
			end
		end
	end
	assign fwd_ok = (rnet_q[ridx] == node_q[63:32]) && (gnet != src_q) && gup_q[cur_g] &&
		port_ok;

	// Byte charge: rounded bytes over header size, plus one. It is registered
	// while the route scan runs, so the charge cycle only adds.
	assign nob_rnd = {1'b0, nob_q} + RndW'(Half);
	assign prod = nob_rnd * DivM24;
	assign quo_w = prod >> DivK;

	// Request capture and scans.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcount_q <= '0;
			guse_q <= '0;
		end else begin
			if (cmd.load_req) begin
				func_q <= func; tnet_q <= dest_net; node_q <= node_id;
				src_q <= src_net; fromif_q <= from_interface; alive_q <= alive;
				when_q <= event_time; now_q <= current_time; nob_q <= payload_bytes;
			end
			if (cmd.gw_start) begin
				gptr_q <= '0; ghit_q <= 1'b0; gfree_q <= 1'b0;
			end
			if (cmd.scan_start) begin
				rptr_q <= (func == wgrt_pkg::FUNC_FWD) ? rcount_q : '0;
				wptr_q <= '0; hit_q <= 1'b0; best_v_q <= 1'b0;
			end
			// Gateway search: first match and first free slot.
			if (cmd.gw_step) begin
				gptr_q <= gptr_q + 1'b1;
				if (guse_q[gp] && gnode_q[gp] == node_q && !ghit_q) begin
					ghit_q <= 1'b1; ghit_idx_q <= gp;
				end
				if (!guse_q[gp] && !gfree_q) begin
					gfree_q <= 1'b1; gfree_idx_q <= gp;
				end
			end
			// Add commit.
			if (cmd.add_commit && st_d == wgrt_pkg::ST_OK) begin
				rnet_q[rcount_q[RW-1:0]] <= tnet_q;
				rcount_q <= rcount_q + 1'b1;
				if (ghit_q) begin
					rgw_q[rcount_q[RW-1:0]] <= ghit_idx_q;
					gusers_q[ghit_idx_q] <= gusers_q[ghit_idx_q] + 1'b1;
				end else begin
					rgw_q[rcount_q[RW-1:0]] <= gfree_idx_q;
					guse_q[gfree_idx_q] <= 1'b1;
					gnode_q[gfree_idx_q] <= node_q;
					gup_q[gfree_idx_q] <= 1'b1;
					gstamp_q[gfree_idx_q] <= '0;
					gusers_q[gfree_idx_q] <= UW'(1);
					for (int g = 0; g < MAX_GATEWAYS; g++) gload_q[g] <= '0;
				end
			end
			// Delete: one route per cycle, compacting survivors.
			if (cmd.del_step) begin
				rptr_q <= rptr_q + 1'b1;
				if (del_m) begin
					hit_q <= 1'b1;
					if (gusers_q[cur_g] <= UW'(1)) begin
						gusers_q[cur_g] <= '0;
						guse_q[cur_g] <= 1'b0;
					end else gusers_q[cur_g] <= gusers_q[cur_g] - 1'b1;
				end else begin
					rnet_q[wptr_q[RW-1:0]] <= rnet_q[ridx];
					rgw_q[wptr_q[RW-1:0]] <= cur_g;
					wptr_q <= wptr_q + 1'b1;
				end
			end
			if (cmd.del_finish) rcount_q <= wptr_q;
			// Notify.
			if (cmd.notify_do && st_d == wgrt_pkg::ST_OK && ghit_q &&
					when_q >= gstamp_q[ghit_idx_q]) begin
				gstamp_q[ghit_idx_q] <= when_q;
				gup_q[ghit_idx_q] <= alive_q;
				if (alive_q && !gup_q[ghit_idx_q])
					for (int g = 0; g < MAX_GATEWAYS; g++) gload_q[g] <= '0;
			end
			// Forward: newest route first.
			if (cmd.fwd_step) begin
				rptr_q <= rtop;
				if (fwd_ok && (!best_v_q ||
						wgrt_pkg::load_better(gload_q[cur_g], gload_q[best_q]))) begin
					best_v_q <= 1'b1; best_q <= cur_g; best_port_q <= port_sel;
				end
			end
			if (cmd.fwd_finish && fwd_en && best_v_q)
				gload_q[best_q] <= gload_q[best_q] + LW'(charge_q);
		end
	end

	// Status of the finishing step.
	always_comb begin
		st_d = wgrt_pkg::ST_OK;
		chg_d = 1'b0;
		case (wgrt_pkg::func_t'(func_q))
			wgrt_pkg::FUNC_ADD: begin
				if (node_q == 64'hffffffffffffffff) st_d = wgrt_pkg::ST_INVAL;
				else if (rcount_q >= CW'(MAX_ROUTES)) st_d = wgrt_pkg::ST_FULL;
				else if (!ghit_q && !gfree_q) st_d = wgrt_pkg::ST_FULL;
			end
			wgrt_pkg::FUNC_DELETE: st_d = hit_q ? wgrt_pkg::ST_OK : wgrt_pkg::ST_NOENT;
			wgrt_pkg::FUNC_NOTIFY: begin
				if ((fromif_q && src_q != node_q[63:32]) || when_q > now_q)
					st_d = wgrt_pkg::ST_INVAL;
				else chg_d = ghit_q && when_q >= gstamp_q[ghit_idx_q] &&
					gup_q[ghit_idx_q] != alive_q;
			end
			default: st_d = (fwd_en && best_v_q) ? wgrt_pkg::ST_OK : wgrt_pkg::ST_UNREACH;
		endcase
	end

	// Result register: status decided in the notify/add/finish cycle is held for output.
	logic [2:0] st_s1;
	logic       chg_s1;
	always_ff @(posedge clk) begin
		charge_q <= quo_w[20:0] + 21'd1;
		if (cmd.add_commit || cmd.notify_do || cmd.del_finish || cmd.fwd_finish) begin
			st_s1 <= st_d; chg_s1 <= chg_d;
		end
		if (cmd.out_load) begin
			status <= st_s1;
			state_changed <= chg_s1;
			if (func_q == wgrt_pkg::FUNC_FWD && st_s1 == wgrt_pkg::ST_OK) begin
				gateway_id <= gnode_q[best_q]; out_port <= best_port_q;
			end else begin
				gateway_id <= '0; out_port <= '0;
			end
		end
	end

	// Route count never exceeds capacity.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rcount_q <= CW'(MAX_ROUTES)) else $error("route count overflow");
	// Delete write pointer trails read pointer.
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del_step |-> wptr_q <= rptr_q) else $error("compaction overrun");
	// Charging only with a chosen gateway.
	a_charge: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fwd_finish && st_d == wgrt_pkg::ST_OK) |-> best_v_q)
		else $error("charge without gateway");
endmodule

// ===== rtl/weighted_gateway_route_table.sv =====
// Weighted gateway route table: top level, channels and configuration registers.
// Depends on wgrt_pkg, wgrt_if, wgrt_ctrl and wgrt_dp.
// Add and notify scan all gateway slots; delete and forward scan the routes;
// forward then charges the chosen gateway; the result may wait on stalls.
// One request at a time: a new one is taken only after the last result is
// loaded. The gateway and route stores are scanned one entry per cycle.
// Reset clears the route count, gateway in-use bits, configuration and control.
`timescale 1ns / 1ps
module weighted_gateway_route_table #(
	parameter int MAX_ROUTES   = wgrt_pkg::MaxRoutesDef,
	parameter int MAX_GATEWAYS = wgrt_pkg::MaxGatewaysDef,
	parameter int HEADER_BYTES = wgrt_pkg::HeaderBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	wgrt_if.sink        req,
	wgrt_if.source      rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic            fwd_en_q;
	logic [3:0][31:0] lnet_q;
	logic [3:0]      lnet_valid_q;
	wgrt_pkg::cmd_t  cmd;
	wgrt_pkg::sts_t  sts;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q <= 1'b0; lnet_q <= '0; lnet_valid_q <= '0;
		end else if (cfg_we) begin
			unique case (wgrt_pkg::cfg_idx_t'(cfg_index))
				wgrt_pkg::CFG_FWD_EN: fwd_en_q <= cfg_data[0];
				wgrt_pkg::CFG_NET0:   lnet_q[0] <= cfg_data;
				wgrt_pkg::CFG_NET1:   lnet_q[1] <= cfg_data;
				wgrt_pkg::CFG_NET2:   lnet_q[2] <= cfg_data;
				wgrt_pkg::CFG_NET3:   lnet_q[3] <= cfg_data;
				wgrt_pkg::CFG_NETVAL: lnet_valid_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	wgrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	wgrt_dp #(
		.MAX_ROUTES(MAX_ROUTES), .MAX_GATEWAYS(MAX_GATEWAYS), .HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(req.data.func), .dest_net(req.data.dest_net), .node_id(req.data.node_id),
		.src_net(req.data.src_net), .from_interface(req.data.from_interface),
		.alive(req.data.alive), .event_time(req.data.event_time),
		.current_time(req.data.current_time), .payload_bytes(req.data.payload_bytes),
		.fwd_en(fwd_en_q), .lnet(lnet_q), .lnet_valid(lnet_valid_q),
		.status(rsp.data.status), .gateway_id(rsp.data.gateway_id),
		.out_port(rsp.data.out_port), .state_changed(rsp.data.state_changed)
	);
endmodule

// ===== bench/wgrt_tb_pkg.sv =====
// Request and result payload types for the route table bench channels.
// Depends on wgrt_pkg for the function codes.
`timescale 1ns / 1ps
package wgrt_tb_pkg;

	typedef struct packed {
		wgrt_pkg::func_t func;
		logic [31:0] dest_net;
		logic [63:0] node_id;
		logic [31:0] src_net;
		logic        from_interface;
		logic        alive;
		logic [31:0] event_time;
		logic [31:0] current_time;
		logic [20:0] payload_bytes;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] gateway_id;
		logic [1:0]  out_port;
		logic        state_changed;
	} rsp_t;

endpackage

// ===== bench/wgrt_checker.sv =====
// Route table checker: mirrors the table state, predicts each result and compares.
// Depends on wgrt_pkg and wgrt_tb_pkg.
`timescale 1ns / 1ps
module wgrt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  wgrt_tb_pkg::req_t req_data,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  wgrt_tb_pkg::rsp_t rsp_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	localparam int NR = 16;
	localparam int NG = 8;
	localparam int HDR = 72;

	// Mirrored configuration.
	logic        m_fwd_en;
	logic [31:0] m_net [4];
	logic [3:0]  m_net_ok;

	// Mirrored table.
	logic [31:0] rt_net [NR];
	logic [2:0]  rt_gw [NR];
	int          rt_cnt;
	logic [63:0] gw_node [NG];
	logic        gw_used [NG];
	logic        gw_up [NG];
	logic [31:0] gw_stamp [NG];
	logic [23:0] gw_load [NG];
	int          gw_users [NG];

	wgrt_tb_pkg::rsp_t expected_results [$];

	function automatic int find_gw(input logic [63:0] node);
		for (int g = 0; g < NG; g++)
			if (gw_used[g] && gw_node[g] == node)
				return g;
		return -1;
	endfunction

	function automatic int port_of(input logic [31:0] net);
		for (int i = 0; i < 4; i++)
			if (m_net_ok[i] && m_net[i] == net)
				return i;
		return -1;
	endfunction

	function automatic logic wrapped_less(input logic [23:0] a, input logic [23:0] b);
		logic [23:0] d;
		d = a - b;
		return d > 24'h7fffff;
	endfunction

	task automatic clear_loads();
		for (int g = 0; g < NG; g++)
			gw_load[g] = '0;
	endtask

	// Apply one request to the mirrored table and work out its result.
	task automatic route_update(input wgrt_tb_pkg::req_t r, output wgrt_tb_pkg::rsp_t e);
		int g;
		int w;
		int best;
		int best_port;
		int p;
		logic hit;
		logic [31:0] gnet;
		e = '{status: wgrt_pkg::ST_OK, gateway_id: '0, out_port: '0, state_changed: 1'b0};
		case (r.func)
			wgrt_pkg::FUNC_ADD: begin
				if (r.node_id == '1)
					e.status = wgrt_pkg::ST_INVAL;
				else if (rt_cnt >= NR)
					e.status = wgrt_pkg::ST_FULL;
				else begin
					g = find_gw(r.node_id);
					if (g < 0) begin
						for (int i = 0; i < NG && g < 0; i++)
							if (!gw_used[i])
								g = i;
						if (g >= 0) begin
							gw_used[g] = 1'b1;
							gw_node[g] = r.node_id;
							gw_up[g] = 1'b1;
							gw_stamp[g] = '0;
							gw_users[g] = 0;
							clear_loads();
						end
					end
					if (g < 0)
						e.status = wgrt_pkg::ST_FULL;
					else begin
						gw_users[g]++;
						rt_net[rt_cnt] = r.dest_net;
						rt_gw[rt_cnt] = g[2:0];
						rt_cnt++;
					end
				end
			end
			wgrt_pkg::FUNC_DELETE: begin
				w = 0;
				hit = 1'b0;
				for (int k = 0; k < rt_cnt; k++) begin
					g = rt_gw[k];
					if ((r.dest_net == '1 || r.dest_net == rt_net[k]) &&
					    (r.node_id == '1 || r.node_id == gw_node[g])) begin
						hit = 1'b1;
						if (gw_users[g] > 0)
							gw_users[g]--;
						if (gw_users[g] == 0)
							gw_used[g] = 1'b0;
					end else begin
						rt_net[w] = rt_net[k];
						rt_gw[w] = rt_gw[k];
						w++;
					end
				end
				rt_cnt = w;
				e.status = hit ? wgrt_pkg::ST_OK : wgrt_pkg::ST_NOENT;
			end
			wgrt_pkg::FUNC_NOTIFY: begin
				if (r.from_interface && r.src_net != r.node_id[63:32])
					e.status = wgrt_pkg::ST_INVAL;
				else if (r.event_time > r.current_time)
					e.status = wgrt_pkg::ST_INVAL;
				else begin
					g = find_gw(r.node_id);
					if (g >= 0 && r.event_time >= gw_stamp[g]) begin
						gw_stamp[g] = r.event_time;
						if (gw_up[g] != r.alive) begin
							gw_up[g] = r.alive;
							if (r.alive)
								clear_loads();
							e.state_changed = 1'b1;
						end
					end
				end
			end
			default: begin
				best = -1;
				best_port = 0;
				if (m_fwd_en) begin
					// Newest route first; a later route wins only on a strictly lower load.
					for (int k = rt_cnt - 1; k >= 0; k--) begin
						g = rt_gw[k];
						gnet = gw_node[g][63:32];
						p = port_of(gnet);
						if (rt_net[k] == r.node_id[63:32] && gnet != r.src_net &&
						    gw_up[g] && p >= 0) begin
							if (best < 0 || wrapped_less(gw_load[g], gw_load[best])) begin
								best = g;
								best_port = p;
							end
						end
					end
				end
				if (best < 0)
					e.status = wgrt_pkg::ST_UNREACH;
				else begin
					gw_load[best] = gw_load[best] + 24'd1 +
						24'((32'(r.payload_bytes) + HDR / 2) / HDR);
					e.gateway_id = gw_node[best];
					e.out_port = best_port[1:0];
				end
			end
		endcase
	endtask

	// Results are compared before the new request is predicted in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		wgrt_tb_pkg::rsp_t exp_r;
		if (!arst_n) begin
			m_fwd_en = 1'b0;
			m_net_ok = '0;
			for (int i = 0; i < 4; i++)
				m_net[i] = '0;
			rt_cnt = 0;
			for (int g = 0; g < NG; g++)
				gw_used[g] = 1'b0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					wgrt_pkg::CFG_FWD_EN: m_fwd_en = cfg_data[0];
					wgrt_pkg::CFG_NET0:   m_net[0] = cfg_data;
					wgrt_pkg::CFG_NET1:   m_net[1] = cfg_data;
					wgrt_pkg::CFG_NET2:   m_net[2] = cfg_data;
					wgrt_pkg::CFG_NET3:   m_net[3] = cfg_data;
					wgrt_pkg::CFG_NETVAL: m_net_ok = cfg_data[3:0];
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %p", rsp_data);
				end else begin
					exp_r = expected_results.pop_front();
					if (rsp_data.status !== exp_r.status ||
					    rsp_data.gateway_id !== exp_r.gateway_id ||
					    rsp_data.out_port !== exp_r.out_port ||
					    rsp_data.state_changed !== exp_r.state_changed) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", exp_r, rsp_data);
					end
				end
			end
			if (req_valid && req_ready) begin
				route_update(req_data, exp_r);
				expected_results.push_back(exp_r);
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== bench/tb_weighted_gateway_route_table.sv =====
// Bench top for the weighted gateway route table: clock, reset, stimulus and verdict.
// Depends on wgrt_pkg, wgrt_tb_pkg, wgrt_if, wgrt_checker and the block itself.
`timescale 1ns / 1ps
module tb_weighted_gateway_route_table;

	localparam int CycleLimit = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        quiet = 1'b0;
	int          fail_count;
	int          pending;
	int          cycles = 0;

	logic [31:0] net_pool [6];
	logic [63:0] node_pool [10];

	wgrt_if #(.payload_t(wgrt_tb_pkg::req_t)) req_ch (clk);
	wgrt_if #(.payload_t(wgrt_tb_pkg::rsp_t)) rsp_ch (clk);

	weighted_gateway_route_table uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	wgrt_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
		.rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always #1 clk = ~clk;

	// Result side stalls at random except during the quiet stretch.
	initial rsp_ch.ready = 1'b0;
	always @(negedge clk)
		rsp_ch.ready = quiet || ($urandom_range(99) >= 38);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb_weighted_gateway_route_table: FAIL");
			$finish;
		end
	end

	// Offer one request, with a random gap before it, and wait for acceptance.
	task automatic send(input wgrt_tb_pkg::req_t it);
		@(negedge clk);
		if (!quiet && $urandom_range(99) < 38) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_ch.data = it;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(input wgrt_pkg::cfg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(input logic en, input logic [31:0] n0, input logic [31:0] n1,
	                         input logic [31:0] n2, input logic [31:0] n3,
	                         input logic [3:0] ok);
		drain();
		write_reg(wgrt_pkg::CFG_FWD_EN, {31'd0, en});
		write_reg(wgrt_pkg::CFG_NET0, n0);
		write_reg(wgrt_pkg::CFG_NET1, n1);
		write_reg(wgrt_pkg::CFG_NET2, n2);
		write_reg(wgrt_pkg::CFG_NET3, n3);
		write_reg(wgrt_pkg::CFG_NETVAL, {28'd0, ok});
	endtask

	function automatic wgrt_tb_pkg::req_t make_req(input wgrt_pkg::func_t f,
	                                               input logic [31:0] net,
	                                               input logic [63:0] node);
		wgrt_tb_pkg::req_t r;
		r = '0;
		r.func = f;
		r.dest_net = net;
		r.node_id = node;
		return r;
	endfunction

	function automatic logic [63:0] pick_node();
		if ($urandom_range(99) < 92)
			return node_pool[$urandom_range(9)];
		return {$urandom, $urandom};
	endfunction

	// Mostly pool values so routes, gateways and local nets line up.
	function automatic wgrt_tb_pkg::req_t random_req();
		wgrt_tb_pkg::req_t r;
		int sel;
		logic [31:0] base;
		sel = $urandom_range(99);
		r.func = sel < 35 ? wgrt_pkg::FUNC_ADD : sel < 50 ? wgrt_pkg::FUNC_DELETE :
		         sel < 70 ? wgrt_pkg::FUNC_NOTIFY : wgrt_pkg::FUNC_FWD;
		r.dest_net = $urandom_range(99) < 10 ? 32'hffffffff :
		             $urandom_range(99) < 5 ? $urandom : net_pool[$urandom_range(5)];
		r.node_id = $urandom_range(99) < 4 ? 64'hffffffffffffffff : pick_node();
		if (r.func == wgrt_pkg::FUNC_FWD)
			r.node_id[63:32] = net_pool[$urandom_range(5)];
		r.src_net = $urandom_range(99) < 40 ? r.node_id[63:32] :
		            $urandom_range(99) < 80 ? net_pool[$urandom_range(5)] : $urandom;
		r.from_interface = 1'($urandom_range(1));
		r.alive = 1'($urandom_range(1));
		base = $urandom_range(99) < 80 ? 32'($urandom_range(400)) : $urandom;
		r.event_time = base;
		r.current_time = $urandom_range(99) < 85 ? base + $urandom_range(50) : $urandom;
		case ($urandom_range(9))
			0: r.payload_bytes = 21'd1048576;
			1: r.payload_bytes = '0;
			2, 3: r.payload_bytes = 21'($urandom_range(1048575));
			default: r.payload_bytes = 21'($urandom_range(3000));
		endcase
		return r;
	endfunction

	initial begin
		wgrt_tb_pkg::req_t r;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		for (int i = 0; i < 6; i++)
			net_pool[i] = $urandom;
		net_pool[4] = 32'h0;
		net_pool[5] = 32'hfffffffe;
		for (int i = 0; i < 10; i++)
			node_pool[i] = {net_pool[i % 6], $urandom};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: argument errors, sharing, notify cases and forward while disabled.
		configure(1'b0, net_pool[0], net_pool[1], net_pool[2], net_pool[3], 4'hf);
		send(make_req(wgrt_pkg::FUNC_ADD, net_pool[2], 64'hffffffffffffffff));
		send(make_req(wgrt_pkg::FUNC_ADD, net_pool[2], node_pool[0]));
		send(make_req(wgrt_pkg::FUNC_ADD, net_pool[3], node_pool[0]));
		send(make_req(wgrt_pkg::FUNC_ADD, net_pool[3], node_pool[1]));
		send(make_req(wgrt_pkg::FUNC_DELETE, 32'h12345678, node_pool[0]));
		r = make_req(wgrt_pkg::FUNC_NOTIFY, 32'd0, node_pool[1]);
		r.from_interface = 1'b1;
		r.src_net = ~node_pool[1][63:32];
		send(r);
		r.from_interface = 1'b0;
		r.event_time = 32'hffffffff;
		r.current_time = 32'hfffffffe;
		send(r);
		r.node_id = 64'h0123456789abcdef;
		r.event_time = 5;
		r.current_time = 32'hffffffff;
		send(r);
		r = make_req(wgrt_pkg::FUNC_NOTIFY, 32'd0, node_pool[1]);
		r.event_time = 20;
		r.current_time = 30;
		send(r);
		r.event_time = 10;
		r.alive = 1'b1;
		send(r);
		r.event_time = 25;
		r.alive = 1'b0;
		send(r);
		r.payload_bytes = 21'd1048576;
		r.func = wgrt_pkg::FUNC_FWD;
		r.node_id = {net_pool[3], 32'd0};
		send(r);

		configure(1'b1, net_pool[0], net_pool[1], net_pool[0], 32'hffffffff, 4'b1110);
		send(r);
		r.func = wgrt_pkg::FUNC_NOTIFY;
		r.node_id = node_pool[1];
		r.alive = 1'b1;
		r.event_time = 26;
		send(r);
		r.func = wgrt_pkg::FUNC_FWD;
		r.node_id = {net_pool[3], 32'hffffffff};
		send(r);
		r.payload_bytes = '0;
		send(r);
		send(make_req(wgrt_pkg::FUNC_DELETE, 32'hffffffff, node_pool[0]));
		send(make_req(wgrt_pkg::FUNC_DELETE, 32'hffffffff, 64'hffffffffffffffff));

		// Random phases over a range of register settings.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(1'b1, net_pool[0], net_pool[1], net_pool[2], net_pool[3], 4'hf);
				1: configure(1'b1, net_pool[4], net_pool[5], net_pool[4], 32'hffffffff, 4'hf);
				2: configure(1'b1, 32'h0, 32'hffffffff, net_pool[1], net_pool[0], 4'h0);
				3: configure(1'b0, net_pool[2], net_pool[3], net_pool[4], net_pool[5], 4'hf);
				4: configure(1'b1, $urandom, net_pool[2], net_pool[5], net_pool[1], 4'($urandom));
				default: configure(1'b1, net_pool[3], net_pool[0], net_pool[5], net_pool[4], 4'hf);
			endcase
			for (int i = 0; i < 172; i++) begin
				quiet = (ph == 1 && i >= 30 && i < 150);
				if (ph == 4 && i == 80) begin
					drain();
				end
				send(random_req());
			end
			quiet = 1'b0;
		end

		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tb_weighted_gateway_route_table: PASS");
		else
			$display("tb_weighted_gateway_route_table: FAIL");
		$finish;
	end

endmodule
